// ===== rtl/spm_pkg.sv =====
// ============================================================================
// spm_pkg
// Shared types, codes and defaults for the sparse polynomial multiplier.
// ============================================================================
package spm_pkg;

    localparam int MAX_TERMS_DEF   = 64;
    localparam int MAX_EXP_DEF     = 63;
    localparam int COEFF_WIDTH_DEF = 16;

    localparam int REQ_W     = 2;
    localparam int COEF_IN_W = 16;
    localparam int EXP_IN_W  = 7;
    localparam int STATUS_W  = 2;
    localparam int ACC_W     = 48;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MUL   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]            req_type;
        logic signed [COEF_IN_W-1:0] coefficient;
        logic [EXP_IN_W-1:0]         exponent;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [ACC_W-1:0] product_coefficient;
        logic                    term_present;
        logic [EXP_IN_W-1:0]     exponent_echo;
    } rsp_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_READ
    } state_t;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
    } pipe_stat_t;

endpackage

// ===== rtl/spm_ram.sv =====
// ============================================================================
// spm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ============================================================================
module spm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/spm_mac.sv =====
// ============================================================================
// spm_mac
// Term multiply and product-store read-modify-write with saturation.
// Stage 1 forms the product index and the product; stage 2 adds, clamps
// and writes back. A write that collides with the next read is forwarded.
// ============================================================================
module spm_mac #(
    parameter int COEFF_WIDTH = spm_pkg::COEFF_WIDTH_DEF,
    parameter int EXP_W       = 6,
    parameter int PIDX_W      = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          issue,
    input  logic signed [COEFF_WIDTH-1:0] term_coeff,
    input  logic [EXP_W-1:0]              term_exp,
    input  logic signed [COEFF_WIDTH-1:0] mul_coeff,
    input  logic [EXP_W-1:0]              mul_exp,
    input  logic [spm_pkg::ACC_W:0]       prod_rdata,
    output logic [PIDX_W-1:0]             prod_raddr,
    output logic                          prod_we,
    output logic [PIDX_W-1:0]             prod_waddr,
    output logic [spm_pkg::ACC_W:0]       prod_wdata,
    output spm_pkg::pipe_stat_t           stat
);

    localparam int ACC_W = spm_pkg::ACC_W;
    localparam int PW    = 2 * COEFF_WIDTH;
    localparam int SUM_W = ((PW > ACC_W) ? PW : ACC_W) + 1;

    logic                    s1_valid_reg, s1_valid_next;
    logic                    s2_valid_reg, s2_valid_next;
    logic signed [PW-1:0]    mul_reg, mul_next;
    logic [PIDX_W-1:0]       k_reg, k_next;
    logic                    fwd_valid_reg, fwd_valid_next;
    logic [PIDX_W-1:0]       fwd_addr_reg, fwd_addr_next;
    logic signed [ACC_W-1:0] fwd_data_reg, fwd_data_next;

    logic signed [ACC_W-1:0] old_val;
    logic signed [SUM_W-1:0] sum;
    logic signed [ACC_W-1:0] sat;
    logic                    no_ovf;

    // stage 1
    always_comb
    begin
        s1_valid_next = issue;
        s2_valid_next = s1_valid_reg;
        k_next        = PIDX_W'(term_exp) + PIDX_W'(mul_exp);
        mul_next      = term_coeff * mul_coeff;
    end

    assign prod_raddr = k_next;

    // stage 2
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == k_reg))
        begin
            old_val = fwd_data_reg;
        end
        else
        begin
            old_val = $signed(prod_rdata[ACC_W-1:0]);
        end
        sum    = SUM_W'(old_val) + SUM_W'(mul_reg);
        no_ovf = (&sum[SUM_W-1:ACC_W-1]) || !(|sum[SUM_W-1:ACC_W-1]);
        if (no_ovf)
        begin
            sat = sum[ACC_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(ACC_W-1){1'b1}}};
        end
        fwd_valid_next = s2_valid_reg;
        fwd_addr_next  = k_reg;
        fwd_data_next  = sat;
    end

    assign prod_we       = s2_valid_reg;
    assign prod_waddr    = k_reg;
    assign prod_wdata    = {1'b1, sat};
    assign stat.s1_valid = s1_valid_reg;
    assign stat.s2_valid = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            mul_reg <= mul_next;
            k_reg   <= k_next;
        end
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

// ===== rtl/sparse_polynomial_multiplier_top.sv =====
// ============================================================================
// sparse_polynomial_multiplier_top
// Sparse polynomial multiplier: term store, product store, sequencer.
// ============================================================================
// Timing: a transfer is taken when start is high and busy is low; its result
// appears on rsp with done high for one cycle and cannot be stalled. For a
// load, an out-of-range item and a multiply with no stored terms the result
// is registered from the accepting cycle; a read passes through the S_READ
// state and the registered product memory read. A multiply walks the stored
// first-polynomial terms one per cycle through the term memory and a
// two-stage read-modify-write on the product memory. Clear sweeps the product
// memory one entry a cycle, and its result follows the last entry. After
// reset the same sweep runs (busy high) with no result.
// ============================================================================
module sparse_polynomial_multiplier_top #(
    parameter int MAX_TERMS   = spm_pkg::MAX_TERMS_DEF,
    parameter int MAX_EXP     = spm_pkg::MAX_EXP_DEF,
    parameter int COEFF_WIDTH = spm_pkg::COEFF_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  spm_pkg::req_t req,
    output logic          done,
    output spm_pkg::rsp_t rsp
);

    localparam int ACC_W      = spm_pkg::ACC_W;
    localparam int PROD_DEPTH = 2 * MAX_EXP + 1;
    localparam int PIDX_W     = $clog2(PROD_DEPTH);
    localparam int EXP_W      = (MAX_EXP > 1) ? $clog2(MAX_EXP + 1) : 1;
    localparam int TA_W       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W      = $clog2(MAX_TERMS + 1);
    localparam int TERM_W     = COEFF_WIDTH + EXP_W;

    spm_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [TA_W-1:0]               idx_reg, idx_next;
    logic [PIDX_W-1:0]             clr_reg, clr_next;
    logic                          sweep_resp_reg, sweep_resp_next;
    logic                          done_reg, done_next;
    spm_pkg::rsp_t                 rsp_reg, rsp_next;
    logic signed [COEFF_WIDTH-1:0] c_reg, c_next;
    logic [EXP_W-1:0]              e_reg, e_next;
    logic [spm_pkg::EXP_IN_W-1:0]  echo_reg, echo_next;

    logic                          accept;
    logic                          exp_over;
    logic                          read_over;
    logic                          full;
    logic                          walk_last;
    logic                          sweep_last;
    logic signed [COEFF_WIDTH-1:0] coeff_in;

    logic                          term_we;
    logic [TA_W-1:0]               term_waddr;
    logic [TERM_W-1:0]             term_wdata;
    logic [TERM_W-1:0]             term_rdata;

    logic                          prod_we;
    logic [PIDX_W-1:0]             prod_waddr;
    logic [ACC_W:0]                prod_wdata;
    logic [PIDX_W-1:0]             prod_raddr;
    logic [ACC_W:0]                prod_rdata;

    logic                          issue;
    logic [PIDX_W-1:0]             mac_raddr;
    logic                          mac_we;
    logic [PIDX_W-1:0]             mac_waddr;
    logic [ACC_W:0]                mac_wdata;
    spm_pkg::pipe_stat_t           mac_stat;

    generate
        if (COEFF_WIDTH <= spm_pkg::COEF_IN_W)
        begin : g_coeff_narrow
            assign coeff_in = req.coefficient[COEFF_WIDTH-1:0];
        end
        else
        begin : g_coeff_wide
            assign coeff_in = {{(COEFF_WIDTH - spm_pkg::COEF_IN_W){
                                  req.coefficient[spm_pkg::COEF_IN_W-1]}},
                               req.coefficient};
        end
    endgenerate

    assign busy       = (state_reg != spm_pkg::S_IDLE);
    assign accept     = start && !busy;
    assign exp_over   = 32'(req.exponent) > 32'(MAX_EXP);
    assign read_over  = 32'(req.exponent) >= 32'(PROD_DEPTH);
    assign full       = (cnt_reg == CNT_W'(MAX_TERMS));
    assign walk_last  = (CNT_W'(idx_reg) == (cnt_reg - CNT_W'(1)));
    assign sweep_last = (clr_reg == PIDX_W'(PROD_DEPTH - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spm_pkg::S_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = spm_pkg::S_IDLE;
                end
            end
            spm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.req_type)
                        spm_pkg::REQ_CLEAR:
                        begin
                            state_next = spm_pkg::S_SWEEP;
                        end
                        spm_pkg::REQ_LOAD:
                        begin
                            state_next = spm_pkg::S_IDLE;
                        end
                        spm_pkg::REQ_MUL:
                        begin
                            if (!exp_over && (cnt_reg != '0))
                            begin
                                state_next = spm_pkg::S_WALK;
                            end
                        end
                        spm_pkg::REQ_READ:
                        begin
                            if (!read_over)
                            begin
                                state_next = spm_pkg::S_READ;
                            end
                        end
                    endcase
                end
            end
            spm_pkg::S_WALK:
            begin
                if (walk_last)
                begin
                    state_next = spm_pkg::S_DRAIN;
                end
            end
            spm_pkg::S_DRAIN:
            begin
                if (!mac_stat.s1_valid && !mac_stat.s2_valid)
                begin
                    state_next = spm_pkg::S_IDLE;
                end
            end
            spm_pkg::S_READ:
            begin
                state_next = spm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = spm_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        clr_next        = clr_reg;
        sweep_resp_next = sweep_resp_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        c_next          = c_reg;
        e_next          = e_reg;
        echo_next       = echo_reg;

        term_we    = 1'b0;
        term_waddr = cnt_reg[TA_W-1:0];
        term_wdata = {coeff_in, EXP_W'(req.exponent)};
        issue      = 1'b0;

        prod_we    = mac_we;
        prod_waddr = mac_waddr;
        prod_wdata = mac_wdata;
        prod_raddr = mac_raddr;

        unique case (state_reg)
            spm_pkg::S_SWEEP:
            begin
                prod_we    = 1'b1;
                prod_waddr = clr_reg;
                prod_wdata = '0;
                clr_next   = clr_reg + PIDX_W'(1);
                if (sweep_last)
                begin
                    clr_next        = '0;
                    sweep_resp_next = 1'b0;
                    if (sweep_resp_reg)
                    begin
                        done_next                    = 1'b1;
                        rsp_next.status              = spm_pkg::ST_OK;
                        rsp_next.product_coefficient = '0;
                        rsp_next.term_present        = 1'b0;
                        rsp_next.exponent_echo       = echo_reg;
                    end
                end
            end
            spm_pkg::S_IDLE:
            begin
                prod_raddr = PIDX_W'(req.exponent);
                if (accept)
                begin
                    echo_next                    = req.exponent;
                    c_next                       = coeff_in;
                    e_next                       = EXP_W'(req.exponent);
                    idx_next                     = '0;
                    rsp_next.status              = spm_pkg::ST_OK;
                    rsp_next.product_coefficient = '0;
                    rsp_next.term_present        = 1'b0;
                    rsp_next.exponent_echo       = req.exponent;
                    unique case (req.req_type)
                        spm_pkg::REQ_CLEAR:
                        begin
                            cnt_next        = '0;
                            sweep_resp_next = 1'b1;
                        end
                        spm_pkg::REQ_LOAD:
                        begin
                            done_next = 1'b1;
                            if (exp_over)
                            begin
                                rsp_next.status = spm_pkg::ST_RANGE;
                            end
                            else if (full)
                            begin
                                rsp_next.status = spm_pkg::ST_FULL;
                            end
                            else
                            begin
                                term_we  = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        spm_pkg::REQ_MUL:
                        begin
                            if (exp_over)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = spm_pkg::ST_RANGE;
                            end
                            else if (cnt_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                        end
                        spm_pkg::REQ_READ:
                        begin
                            if (read_over)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = spm_pkg::ST_RANGE;
                            end
                        end
                    endcase
                end
            end
            spm_pkg::S_WALK:
            begin
                issue    = 1'b1;
                idx_next = idx_reg + TA_W'(1);
            end
            spm_pkg::S_DRAIN:
            begin
                if (!mac_stat.s1_valid && !mac_stat.s2_valid)
                begin
                    done_next = 1'b1;
                end
            end
            spm_pkg::S_READ:
            begin
                done_next                    = 1'b1;
                rsp_next.product_coefficient = $signed(prod_rdata[ACC_W-1:0]);
                rsp_next.term_present        = prod_rdata[ACC_W];
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    spm_ram #(
        .WIDTH (TERM_W),
        .DEPTH (MAX_TERMS),
        .AW    (TA_W)
    ) u_term_ram (
        .clk   (clk),
        .we    (term_we),
        .waddr (term_waddr),
        .wdata (term_wdata),
        .raddr (idx_reg),
        .rdata (term_rdata)
    );

    spm_ram #(
        .WIDTH (ACC_W + 1),
        .DEPTH (PROD_DEPTH),
        .AW    (PIDX_W)
    ) u_prod_ram (
        .clk   (clk),
        .we    (prod_we),
        .waddr (prod_waddr),
        .wdata (prod_wdata),
        .raddr (prod_raddr),
        .rdata (prod_rdata)
    );

    spm_mac #(
        .COEFF_WIDTH (COEFF_WIDTH),
        .EXP_W       (EXP_W),
        .PIDX_W      (PIDX_W)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (issue),
        .term_coeff ($signed(term_rdata[TERM_W-1:EXP_W])),
        .term_exp   (term_rdata[EXP_W-1:0]),
        .mul_coeff  (c_reg),
        .mul_exp    (e_reg),
        .prod_rdata (prod_rdata),
        .prod_raddr (mac_raddr),
        .prod_we    (mac_we),
        .prod_waddr (mac_waddr),
        .prod_wdata (mac_wdata),
        .stat       (mac_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spm_pkg::S_SWEEP;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            clr_reg        <= '0;
            sweep_resp_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            clr_reg        <= clr_next;
            sweep_resp_reg <= sweep_resp_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        c_reg    <= c_next;
        e_reg    <= e_next;
        echo_reg <= echo_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef NO_ASSERTIONS
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spm_pkg::S_WALK) |-> (CNT_W'(idx_reg) < cnt_reg))
        else $error("walk index beyond stored term count");

    a_prod_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        prod_we |-> (state_reg != spm_pkg::S_IDLE) && (state_reg != spm_pkg::S_READ))
        else $error("product store written outside sweep or multiply");

    a_term_wr_accept: assert property (@(posedge clk) disable iff (!rst_n)
        term_we |-> (accept && (req.req_type == spm_pkg::REQ_LOAD)))
        else $error("term store written without a load transfer");

    a_reset_sweep_silent: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == spm_pkg::S_SWEEP) && sweep_last && !sweep_resp_reg) |=> !done_reg)
        else $error("result produced by the power-on clear sweep");

    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == spm_pkg::S_DRAIN) && !mac_stat.s1_valid && !mac_stat.s2_valid)
        |=> done_reg && !mac_stat.s2_valid)
        else $error("multiply finished with write-back pending");
`endif

endmodule

// ===== test/testbench.sv =====
// ============================================================================
// testbench
// Checks the sparse polynomial multiplier against an in-bench product model.
// Every accepted request is run through the model, and each response is
// compared field by field with the oldest expected one. Stimulus is a short
// directed set, then a buffer-full and large-sum pass, then random
// clear/load/multiply/read sequences mixed with noise under three sender
// idle rates.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_TERMS   = spm_pkg::MAX_TERMS_DEF;
    localparam int     MAX_EXP     = spm_pkg::MAX_EXP_DEF;
    localparam int     REQ_W       = spm_pkg::REQ_W;
    localparam int     COEF_IN_W   = spm_pkg::COEF_IN_W;
    localparam int     EXP_IN_W    = spm_pkg::EXP_IN_W;
    localparam int     ACC_W       = spm_pkg::ACC_W;
    localparam int     PROD_DEPTH  = 2 * MAX_EXP + 1;
    localparam longint ACC_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN     = -ACC_MAX - 1;
    localparam int     CYCLE_LIMIT = 2_500_000;
    localparam int     BIG_REPS    = 16;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    spm_pkg::req_t req;
    logic          done;
    spm_pkg::rsp_t rsp;

    sparse_polynomial_multiplier_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // product model state
    logic signed [COEF_IN_W-1:0] term_coef [MAX_TERMS];
    logic [5:0]                  term_exp  [MAX_TERMS];
    int                          term_count;
    logic signed [ACC_W-1:0]     prod_coef [PROD_DEPTH];
    logic                        prod_mark [PROD_DEPTH];

    spm_pkg::rsp_t pending_rsp [$];
    int            idle_pct;
    int            sent_cnt;
    int            mismatch_cnt;
    int            cycle_cnt;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic spm_pkg::rsp_t predict_product_response(spm_pkg::req_t item);
        spm_pkg::rsp_t r;
        int            i;
        int            k;
        longint        acc;
        r = '0;
        r.status = spm_pkg::ST_OK;
        r.exponent_echo = item.exponent;
        case (item.req_type)
            spm_pkg::REQ_CLEAR:
            begin
                for (k = 0; k < PROD_DEPTH; k++)
                begin
                    prod_coef[k[6:0]] = '0;
                    prod_mark[k[6:0]] = 1'b0;
                end
                term_count = 0;
            end
            spm_pkg::REQ_LOAD:
            begin
                if (item.exponent > MAX_EXP)
                    r.status = spm_pkg::ST_RANGE;
                else if (term_count >= MAX_TERMS)
                    r.status = spm_pkg::ST_FULL;
                else
                begin
                    term_coef[term_count[5:0]] = item.coefficient;
                    term_exp[term_count[5:0]] = item.exponent[5:0];
                    term_count++;
                end
            end
            spm_pkg::REQ_MUL:
            begin
                if (item.exponent > MAX_EXP)
                    r.status = spm_pkg::ST_RANGE;
                else
                begin
                    for (i = 0; i < term_count; i++)
                    begin
                        k = int'(term_exp[i[5:0]]) + int'(item.exponent);
                        if (k < PROD_DEPTH)
                        begin
                            acc = longint'(prod_coef[k[6:0]])
                                + longint'(term_coef[i[5:0]]) * longint'(item.coefficient);
                            if (acc > ACC_MAX)
                                acc = ACC_MAX;
                            if (acc < ACC_MIN)
                                acc = ACC_MIN;
                            prod_coef[k[6:0]] = acc[ACC_W-1:0];
                            prod_mark[k[6:0]] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                if (item.exponent >= PROD_DEPTH)
                    r.status = spm_pkg::ST_RANGE;
                else
                begin
                    r.product_coefficient = prod_coef[item.exponent];
                    r.term_present = prod_mark[item.exponent];
                end
            end
        endcase
        return r;
    endfunction

    task automatic flag_error(string msg);
        if (mismatch_cnt < 10)
            $display("%s", msg);
        mismatch_cnt++;
    endtask

    always @(posedge clk)
    begin : check_results
        spm_pkg::rsp_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_rsp.size() == 0)
                flag_error($sformatf("%0t: unexpected result status=%0d coef=%0d exp=%0d",
                                     $realtime, rsp.status, rsp.product_coefficient,
                                     rsp.exponent_echo));
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp !== want)
                    flag_error($sformatf(
                        "%0t: mismatch exp status=%0d coef=%0d pres=%0b echo=%0d, got %0d %0d %0b %0d",
                        $realtime, want.status, want.product_coefficient,
                        want.term_present, want.exponent_echo, rsp.status,
                        rsp.product_coefficient, rsp.term_present, rsp.exponent_echo));
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send(logic [REQ_W-1:0] kind, logic [COEF_IN_W-1:0] coef,
                        logic [EXP_IN_W-1:0] ex);
        spm_pkg::req_t item;
        item.req_type = kind;
        item.coefficient = coef;
        item.exponent = ex;
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        req = item;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_rsp.push_back(predict_product_response(item));
        sent_cnt++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        start = 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [COEF_IN_W-1:0] pick_coef();
        int v;
        case ($urandom_range(0, 7))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            3, 4: v = int'($urandom_range(0, 16)) - 8;
            default: v = $urandom;
        endcase
        return v[COEF_IN_W-1:0];
    endfunction

    function automatic logic [EXP_IN_W-1:0] pick_term_exp();
        if ($urandom_range(99) < 5)
            return EXP_IN_W'($urandom_range(MAX_EXP + 1, 127));
        return EXP_IN_W'($urandom_range(0, MAX_EXP));
    endfunction

    // favor exponents that carry a product term
    function automatic logic [EXP_IN_W-1:0] pick_read_exp();
        int k;
        repeat (8)
        begin
            k = int'($urandom_range(0, PROD_DEPTH - 1));
            if (prod_mark[k[6:0]])
                return k[6:0];
        end
        return EXP_IN_W'($urandom_range(0, 127));
    endfunction

    task automatic test_directed_terms();
        send(spm_pkg::REQ_READ, 16'd0, 7'd0);
        send(spm_pkg::REQ_READ, 16'd0, 7'd127);
        send(spm_pkg::REQ_MUL, 16'd5, 7'd3);
        send(spm_pkg::REQ_READ, 16'd0, 7'd3);
        send(spm_pkg::REQ_LOAD, 16'h8000, 7'd63);
        send(spm_pkg::REQ_LOAD, 16'h7fff, 7'd0);
        send(spm_pkg::REQ_LOAD, 16'd2, 7'd10);
        send(spm_pkg::REQ_LOAD, 16'hfffe, 7'd10);
        send(spm_pkg::REQ_LOAD, 16'd7, 7'd64);
        send(spm_pkg::REQ_LOAD, 16'd1, 7'd127);
        send(spm_pkg::REQ_MUL, 16'h8000, 7'd63);
        send(spm_pkg::REQ_MUL, 16'h7fff, 7'd0);
        send(spm_pkg::REQ_MUL, 16'd1, 7'd100);
        send(spm_pkg::REQ_READ, 16'hffff, 7'd126);
        send(spm_pkg::REQ_READ, 16'd0, 7'd63);
        send(spm_pkg::REQ_READ, 16'd0, 7'd73);
        send(spm_pkg::REQ_READ, 16'd0, 7'd0);
        send(spm_pkg::REQ_READ, 16'd0, 7'd10);
        send(spm_pkg::REQ_READ, 16'd0, 7'd1);
        send(spm_pkg::REQ_CLEAR, 16'hffff, 7'd127);
        send(spm_pkg::REQ_READ, 16'd0, 7'd126);
    endtask

    task automatic test_full_and_large_sums();
        send(spm_pkg::REQ_CLEAR, 16'd0, 7'd0);
        repeat (MAX_TERMS) send(spm_pkg::REQ_LOAD, 16'h8000, 7'd0);
        send(spm_pkg::REQ_LOAD, 16'd1, 7'd5);
        send(spm_pkg::REQ_LOAD, 16'd1, 7'd64);
        repeat (BIG_REPS) send(spm_pkg::REQ_MUL, 16'h8000, 7'd0);
        send(spm_pkg::REQ_READ, 16'd0, 7'd0);
        send(spm_pkg::REQ_MUL, 16'h7fff, 7'd0);
        send(spm_pkg::REQ_READ, 16'd0, 7'd0);
        repeat (BIG_REPS) send(spm_pkg::REQ_MUL, 16'h7fff, 7'd1);
        send(spm_pkg::REQ_READ, 16'd0, 7'd1);
        send(spm_pkg::REQ_MUL, 16'hffff, 7'd1);
        send(spm_pkg::REQ_READ, 16'd0, 7'd1);
        send(spm_pkg::REQ_CLEAR, 16'd0, 7'd0);
    endtask

    task automatic test_random(int n_items, int pct);
        int first;
        int n_terms;
        idle_pct = pct;
        first = sent_cnt;
        while (sent_cnt - first < n_items)
        begin
            if ($urandom_range(99) < 15)
                repeat ($urandom_range(1, 4))
                    send(REQ_W'($urandom_range(0, 3)), COEF_IN_W'($urandom),
                         EXP_IN_W'($urandom_range(0, 127)));
            else
            begin
                if ($urandom_range(99) < 70)
                    send(spm_pkg::REQ_CLEAR, pick_coef(),
                         EXP_IN_W'($urandom_range(0, 127)));
                n_terms = ($urandom_range(99) < 8) ? $urandom_range(56, 70)
                                                   : $urandom_range(1, 10);
                repeat (n_terms) send(spm_pkg::REQ_LOAD, pick_coef(), pick_term_exp());
                repeat ($urandom_range(1, 5))
                    send(spm_pkg::REQ_MUL, pick_coef(), pick_term_exp());
                repeat ($urandom_range(2, 8))
                    send(spm_pkg::REQ_READ, pick_coef(), pick_read_exp());
            end
        end
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        idle_pct = 26;
        sent_cnt = 0;
        mismatch_cnt = 0;
        cycle_cnt = 0;
        term_count = 0;
        for (k = 0; k < PROD_DEPTH; k++)
        begin
            prod_coef[k[6:0]] = '0;
            prod_mark[k[6:0]] = 1'b0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_terms();
        wait_for_results();
        test_full_and_large_sums();
        wait_for_results();
        test_random(240, 26);
        wait_for_results();
        test_random(240, 80);
        wait_for_results();
        test_random(240, 0);
        wait_for_results();
        repeat (20) @(posedge clk);

        if (mismatch_cnt == 0 && pending_rsp.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
